/* design/bebd_pkg.sv */
// Shared types, constants and helpers for the band energy beat detector.
// Depends on nothing; every other design file imports it.
package bebd_pkg;

  localparam int BANDS       = 8;
  localparam int HIST_DEPTH  = 64;
  localparam int BAND_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int ENERGY_W    = 43;
  localparam int POS_W       = $clog2(HIST_DEPTH);
  localparam int LEN_W       = 7;
  localparam int TOTAL_W     = ENERGY_W + POS_W;
  localparam int SENS_W      = 12;
  localparam int FRAC_W      = 8;
  localparam int LHS_W       = ENERGY_W + LEN_W;
  localparam int CMP_W       = SENS_W + TOTAL_W;
  localparam int RING_AW     = BAND_W + POS_W;
  localparam int RING_ENTRIES = 1 << RING_AW;

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 2 * SAMPLE_W;
  localparam int OUT_TDATA_W = ((ENERGY_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = BAND_W + 1;

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = FIFO_AW + 1;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [SENS_W-1:0]   SENS_RESET = 12'd333;
  localparam logic [LEN_W-1:0]    LEN_RESET  = 7'd43;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSITIVITY    = 8'd0,
    REG_HISTORY_LENGTH = 8'd1
  } cfg_reg_t;

  // Per-band state record kept in the band memory
  typedef struct packed {
    logic [ENERGY_W-1:0] acc;
    logic [TOTAL_W-1:0]  total;
    logic [POS_W-1:0]    pos;
    logic                full;
  } band_rec_t;

  typedef struct packed {
    logic [BAND_W-1:0]   band;
    logic                beat;
    logic [ENERGY_W-1:0] energy;
  } result_t;

  function automatic logic [SQ_W-1:0] square_mag(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] mag;
    mag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = v;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(HIST_DEPTH)) n = LEN_W'(HIST_DEPTH);
    return n;
  endfunction

endpackage

/* design/bebd_ring_ram.sv */
// History ring memory: one entry per band and ring slot, read-first.
// Depends on bebd_pkg.
module bebd_ring_ram import bebd_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [RING_AW-1:0]  wr_addr,
  input  logic [ENERGY_W-1:0] wr_data,
  input  logic [RING_AW-1:0]  rd_addr,
  output logic [ENERGY_W-1:0] rd_data
);

  logic [ENERGY_W-1:0] mem [RING_ENTRIES];
  logic [ENERGY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/bebd_band_ram.sv */
// Per-band state memory with valid bits that stand for the reset value.
// Depends on bebd_pkg.
module bebd_band_ram import bebd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BAND_W-1:0] rd_band,
  output band_rec_t         rd_rec,
  input  logic              wr_en,
  input  logic [BAND_W-1:0] wr_band,
  input  band_rec_t         wr_rec,
  input  logic              hist_clr
);

  band_rec_t        mem [BANDS];
  band_rec_t        rd_data_r;
  logic [BANDS-1:0] acc_vld_r;
  logic [BANDS-1:0] hist_vld_r;
  logic             rd_acc_vld_r;
  logic             rd_hist_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_band] <= wr_rec;
    end
    rd_data_r <= mem[rd_band];
  end

  // Accumulator survives a history clear; ring bookkeeping does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r     <= '0;
      hist_vld_r    <= '0;
      rd_acc_vld_r  <= 1'b0;
      rd_hist_vld_r <= 1'b0;
    end else begin
      rd_acc_vld_r  <= acc_vld_r[rd_band];
      rd_hist_vld_r <= hist_vld_r[rd_band];
      if (wr_en) begin
        acc_vld_r[wr_band] <= 1'b1;
      end
      if (hist_clr) begin
        hist_vld_r <= '0;
      end else if (wr_en) begin
        hist_vld_r[wr_band] <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_rec = rd_data_r;
    if (!rd_acc_vld_r) begin
      rd_rec.acc = '0;
    end
    if (!rd_hist_vld_r) begin
      rd_rec.total = '0;
      rd_rec.pos   = '0;
      rd_rec.full  = 1'b0;
    end
  end

endmodule

/* design/bebd_result_fifo.sv */
// Result queue that parts the pipeline from the output channel.
// Depends on bebd_pkg.
module bebd_result_fifo import bebd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  result_t            push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_data,
  output logic [FIFO_CW-1:0] count
);

  result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_AW-1:0] tail_r, tail_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[head_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    head_nxt = pop  ? head_r + 1'b1 : head_r;
    tail_nxt = push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue pushed while full");

endmodule

/* design/band_energy_beat_detector.sv */
// Band energy beat detector, top level.
// Depends on bebd_pkg, bebd_band_ram, bebd_ring_ram and bebd_result_fifo.
//
// Usage:
//   in_*  : one stereo sample word per accept; tuser carries the band,
//           tlast marks the last sample of that band's chunk.
//   out_* : one word per completed chunk: tuser holds band and beat flag,
//           tdata the saturated chunk energy.
//   cfg_* : register writes (sensitivity, history_length); cfg_ready is
//           always high. Write only while the block is idle. Writing
//           history_length empties every band's history ring.
// Throughput: one sample word per cycle while in_tready is high, any band order.
// Path: a result word passes the stage-1, stage-2 and stage-3 registers
//   and the result queue before out_tvalid shows it. The stages follow the band-state
//   read-modify-write: band memory read, accumulate, ring read, total
//   update and write back, with forwarding from the two newest writes.
// Reset: valid bits stand for the zeroed state, no sweep.
// Stall: results wait in an 8-word queue. in_tready drops once queued
//   words plus chunk ends still in flight reach the queue depth, and
//   rises again as the receiver drains it. No word is ever dropped.
module band_energy_beat_detector import bebd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic [BAND_W-1:0]      in_tuser,   // [2:0] band
  input  logic                   in_tlast,   // chunk_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [42:0] chunk_energy, [47:43] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [2:0] band_out, [3] beat
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // ---------------- configuration ----------------
  logic [SENS_W-1:0] sens_r, sens_nxt;
  logic [LEN_W-1:0]  len_eff_r, len_nxt;
  logic              hist_clr;

  assign cfg_ready = 1'b1;

  always_comb begin
    sens_nxt = sens_r;
    len_nxt  = len_eff_r;
    hist_clr = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENSITIVITY: sens_nxt = cfg_data[SENS_W-1:0];
        REG_HISTORY_LENGTH: begin
          // hold the clamped length so the pipeline never clamps again
          len_nxt  = eff_len(cfg_data[LEN_W-1:0]);
          hist_clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r    <= SENS_RESET;
      len_eff_r <= LEN_RESET;
    end else begin
      sens_r    <= sens_nxt;
      len_eff_r <= len_nxt;
    end
  end

  // ---------------- accept stage ----------------
  logic [BAND_W-1:0]  in_band;
  logic               band_ok;
  logic               in_acc;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW:0]   res_cnt;

  logic               s1_vld_r, s1_end_r;
  logic [BAND_W-1:0]  s1_band_r;
  logic [SQ_W-1:0]    s1_sql_r, s1_sqr_r;

  logic               s2_vld_r, s2_end_r;
  logic               s3_vld_r;

  assign in_band = in_tuser;
  assign band_ok = (32'(in_band) < BANDS);
  assign in_acc  = in_tvalid && in_tready;

  // Reserve a queue slot for every chunk end already in the pipeline
  assign res_cnt = (FIFO_CW+1)'(fifo_cnt)
                 + (FIFO_CW+1)'(s1_vld_r && s1_end_r)
                 + (FIFO_CW+1)'(s2_vld_r && s2_end_r)
                 + (FIFO_CW+1)'(s3_vld_r);
  assign in_tready = (res_cnt < (FIFO_CW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc && band_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_band_r <= in_band;
      s1_end_r  <= in_tlast;
      s1_sql_r  <= square_mag(in_tdata[SAMPLE_W-1:0]);
      s1_sqr_r  <= square_mag(in_tdata[IN_TDATA_W-1:SAMPLE_W]);
    end
  end

  // ---------------- band state memory ----------------
  band_rec_t         mem_rec;
  band_rec_t         s2_wr_rec;
  logic [BAND_W-1:0] s2_band_r;

  bebd_band_ram u_band_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_band  (in_band),
    .rd_rec   (mem_rec),
    .wr_en    (s2_vld_r),
    .wr_band  (s2_band_r),
    .wr_rec   (s2_wr_rec),
    .hist_clr (hist_clr)
  );

  // ---------------- stage 1: accumulate, pick ring slot ----------------
  logic              w3_vld_r;
  logic [BAND_W-1:0] w3_band_r;
  band_rec_t         w3_rec_r;

  band_rec_t           rec_cur;
  logic [ENERGY_W:0]   acc_sum;
  logic [ENERGY_W-1:0] s1_e;
  logic [POS_W-1:0]    s1_pos, s1_npos;
  logic [LEN_W-1:0]    pos_inc;
  logic                s1_wrap;
  logic                s1_ring_fwd;
  logic [RING_AW-1:0]  ring_rd_addr;

  logic [ENERGY_W-1:0] s2_e_r, s2_acc_r, s2_fwd_e_r;
  logic [TOTAL_W-1:0]  s2_total_r;
  logic [POS_W-1:0]    s2_wpos_r, s2_npos_r;
  logic                s2_nfull_r, s2_old_vld_r, s2_ring_fwd_r;

  always_comb begin
    // forward the two newest write-backs over the stale memory word
    rec_cur = mem_rec;
    if (w3_vld_r && (w3_band_r == s1_band_r)) begin
      rec_cur = w3_rec_r;
    end
    if (s2_vld_r && (s2_band_r == s1_band_r)) begin
      rec_cur = s2_wr_rec;
    end

    acc_sum = (ENERGY_W+1)'(rec_cur.acc) + (ENERGY_W+1)'(s1_sql_r)
            + (ENERGY_W+1)'(s1_sqr_r);
    s1_e    = acc_sum[ENERGY_W] ? ENERGY_MAX : acc_sum[ENERGY_W-1:0];

    s1_pos  = (LEN_W'(rec_cur.pos) >= len_eff_r) ? '0 : rec_cur.pos;
    pos_inc = LEN_W'(s1_pos) + LEN_W'(1);
    s1_wrap = (pos_inc >= len_eff_r);
    s1_npos = s1_wrap ? '0 : pos_inc[POS_W-1:0];

    // a one-slot ring rewrites the slot the older chunk just wrote
    s1_ring_fwd  = s2_vld_r && s2_end_r && (s2_band_r == s1_band_r)
                && (s2_wpos_r == s1_pos);
    ring_rd_addr = {s1_band_r, s1_pos};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_end_r      <= s1_end_r;
    s2_band_r     <= s1_band_r;
    s2_e_r        <= s1_e;
    s2_acc_r      <= s1_end_r ? '0 : s1_e;
    s2_total_r    <= rec_cur.total;
    s2_wpos_r     <= s1_pos;
    s2_npos_r     <= s1_end_r ? s1_npos : rec_cur.pos;
    s2_nfull_r    <= s1_end_r ? (rec_cur.full | s1_wrap) : rec_cur.full;
    s2_old_vld_r  <= rec_cur.full;
    s2_ring_fwd_r <= s1_ring_fwd;
    s2_fwd_e_r    <= s2_e_r;
  end

  // ---------------- history ring ----------------
  logic [ENERGY_W-1:0] ring_rd_data;

  bebd_ring_ram u_ring_ram (
    .clk     (clk),
    .wr_en   (s2_vld_r && s2_end_r),
    .wr_addr ({s2_band_r, s2_wpos_r}),
    .wr_data (s2_e_r),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  // ---------------- stage 2: total update, products ----------------
  logic [ENERGY_W-1:0] ring_old;
  logic [TOTAL_W-1:0]  total_new;
  logic [LHS_W-1:0]    lhs_prod;
  logic [CMP_W-1:0]    rhs_prod;

  logic [BAND_W-1:0]   s3_band_r;
  logic [ENERGY_W-1:0] s3_e_r;
  logic [LHS_W-1:0]    s3_lhs_r;
  logic [CMP_W-1:0]    s3_rhs_r;

  always_comb begin
    // a slot not yet filled since the last clear reads as zero
    ring_old  = s2_ring_fwd_r ? s2_fwd_e_r : (s2_old_vld_r ? ring_rd_data : '0);
    total_new = s2_end_r ? (s2_total_r - TOTAL_W'(ring_old) + TOTAL_W'(s2_e_r))
                         : s2_total_r;
    s2_wr_rec = '{acc: s2_acc_r, total: total_new, pos: s2_npos_r, full: s2_nfull_r};
    lhs_prod  = LHS_W'(s2_e_r) * LHS_W'(len_eff_r);
    rhs_prod  = CMP_W'(sens_r) * CMP_W'(s2_total_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w3_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      w3_vld_r <= s2_vld_r;
      s3_vld_r <= s2_vld_r && s2_end_r;
    end
  end

  always_ff @(posedge clk) begin
    w3_band_r <= s2_band_r;
    w3_rec_r  <= s2_wr_rec;
    s3_band_r <= s2_band_r;
    s3_e_r    <= s2_e_r;
    s3_lhs_r  <= lhs_prod;
    s3_rhs_r  <= rhs_prod;
  end

  // ---------------- stage 3: compare, queue result ----------------
  logic    s3_hit;
  result_t s3_res;
  result_t out_res;

  assign s3_hit = (CMP_W'({s3_lhs_r, FRAC_W'(0)}) > s3_rhs_r);
  assign s3_res = '{band: s3_band_r, beat: s3_hit, energy: s3_e_r};

  bebd_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_vld_r),
    .push_data (s3_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res),
    .count     (fifo_cnt)
  );

  assign out_tdata = OUT_TDATA_W'(out_res.energy);
  assign out_tuser = {out_res.beat, out_res.band};

  // ---------------- checks ----------------
  a_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt <= (FIFO_CW+1)'(FIFO_DEPTH))
    else $error("queue reservation exceeds depth");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_end_r) |-> (LEN_W'(s2_wpos_r) < len_eff_r))
    else $error("ring slot beyond history length");

  a_ring_fwd_len1: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_end_r && s2_ring_fwd_r) |-> (len_eff_r == LEN_W'(1)))
    else $error("ring slot collision with history length above one");

endmodule

/* tb/sv/band_energy_beat_detector_chk.sv */
// Checker for the band energy beat detector: watches the cfg, in and out channels.
// Predicts every chunk-end word from its own copy of the band state and compares.
// Depends on bebd_pkg for widths, register codes and the result record.
module band_energy_beat_detector_chk
  import bebd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [BAND_W-1:0]      in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  logic [SENS_W-1:0]   sens_q;
  logic [LEN_W-1:0]    len_q;
  logic [ENERGY_W-1:0] acc_q   [BANDS];
  logic [ENERGY_W-1:0] ring_q  [BANDS][HIST_DEPTH];
  int unsigned         slot_q  [BANDS];
  logic [TOTAL_W-1:0]  total_q [BANDS];
  result_t             awaited_chunks [$];
  int                  bad_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void wipe_history();
    foreach (ring_q[b, k]) ring_q[b][k] = '0;
    foreach (slot_q[b]) begin
      slot_q[b]  = 0;
      total_q[b] = '0;
    end
  endfunction

  function automatic longint unsigned power_of(input logic [SAMPLE_W-1:0] s);
    int m;
    m = $signed(s);
    if (m < 0) m = -m;
    return longint'(m) * longint'(m);
  endfunction

  // Fold one sample into its band; on a chunk end, judge the beat and push the
  // energy into the band's ring. Returns 1 when a result word is due.
  function automatic logic fold_sample(input logic [BAND_W-1:0] b,
                                       input logic [SAMPLE_W-1:0] l,
                                       input logic [SAMPLE_W-1:0] r,
                                       input logic last,
                                       output result_t word);
    longint unsigned e;
    longint unsigned lhs;
    longint unsigned rhs;
    int unsigned     span;
    int unsigned     slot;
    word = '0;
    e = 64'(acc_q[b]) + power_of(l) + power_of(r);
    if (e > 64'(ENERGY_MAX)) e = 64'(ENERGY_MAX);
    if (!last) begin
      acc_q[b] = e[ENERGY_W-1:0];
      return 1'b0;
    end
    span = (len_q == '0) ? 1 : (len_q > HIST_DEPTH) ? HIST_DEPTH : len_q;
    lhs  = e * span * 256;
    rhs  = 64'(sens_q) * 64'(total_q[b]);
    slot = slot_q[b];
    if (slot >= span) slot = 0;
    total_q[b] = total_q[b] - TOTAL_W'(ring_q[b][slot]) + TOTAL_W'(e);
    ring_q[b][slot] = e[ENERGY_W-1:0];
    slot++;
    if (slot >= span) slot = 0;
    slot_q[b] = slot;
    acc_q[b]  = '0;
    word.band   = b;
    word.beat   = lhs > rhs;
    word.energy = e[ENERGY_W-1:0];
    return 1'b1;
  endfunction

  task automatic flag_fault(input string what);
    bad_count++;
    if (bad_count <= REPORT_MAX) $display("band_energy_beat_detector_chk: %s", what);
  endtask

  always @(posedge clk) begin : watch
    result_t due;
    logic    fresh;
    if (!rst_n) begin
      sens_q = SENS_RESET;
      len_q  = LEN_RESET;
      foreach (acc_q[b]) acc_q[b] = '0;
      wipe_history();
      awaited_chunks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SENSITIVITY) begin
          sens_q = cfg_data[SENS_W-1:0];
        end else if (cfg_index == REG_HISTORY_LENGTH) begin
          len_q = cfg_data[LEN_W-1:0];
          wipe_history();
        end
      end
      if (out_tvalid && out_tready) begin
        if (awaited_chunks.size() == 0) begin
          flag_fault($sformatf("unexpected word band %0d beat %0b energy %0d",
                               out_tuser[BAND_W-1:0], out_tuser[BAND_W], out_tdata));
        end else begin
          due = awaited_chunks.pop_front();
          if (out_tuser[BAND_W-1:0] != due.band || out_tuser[BAND_W] != due.beat ||
              out_tdata != OUT_TDATA_W'(due.energy))
            flag_fault($sformatf(
              "expected band %0d beat %0b energy %0d, got band %0d beat %0b energy %0d",
              due.band, due.beat, due.energy,
              out_tuser[BAND_W-1:0], out_tuser[BAND_W], out_tdata));
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = fold_sample(in_tuser, in_tdata[SAMPLE_W-1:0],
                            in_tdata[2*SAMPLE_W-1:SAMPLE_W], in_tlast, due);
        if (fresh) awaited_chunks.push_back(due);
      end
    end
    outstanding <= awaited_chunks.size();
    mismatches  <= bad_count;
  end

endmodule

/* tb/sv/band_energy_beat_detector_tb.sv */
// Top-level bench for band_energy_beat_detector: clock, reset, stimulus, verdict.
// Depends on bebd_pkg, the design and band_energy_beat_detector_chk.
module band_energy_beat_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bebd_pkg::*;

  // Generous cycle ceiling; a correct run needs a small fraction of it.
  localparam int unsigned LIMIT = 300000;
  // Cycles to let the pipeline empty after the last word is out.
  localparam int          DRAIN = 8;
  // Samples before the closing one in the long full-scale chunk that drives one band's energy high.
  localparam int          LONG_RUN = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [15:0] left_sample, [31:16] right_sample
  logic [BAND_W-1:0]      in_tuser   = '0;   // [2:0] band
  logic                   in_tlast   = 1'b0; // chunk_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [42:0] chunk_energy, [47:43] zero
  logic [OUT_TUSER_W-1:0] out_tuser;         // [2:0] band_out, [3] beat
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int          mismatches;
  int          outstanding;
  int unsigned ticks      = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;           // both sides run without gaps while set
  logic [3:0]  amp_shift [BANDS];           // per-band loudness of the current chunk

  band_energy_beat_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  band_energy_beat_detector_chk energy_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    ticks <= ticks + 1;
    if (ticks >= LIMIT) begin
      $display("band_energy_beat_detector_tb: FAIL");
      $finish;
    end
  end

  // Receiver: drop ready about a third of the time; now and then hold it low
  // long enough to fill the result queue and push back on the input side.
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < 32) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(39) == 0) ? $urandom_range(24, 8) : 0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Mostly scaled random audio, with the two full-scale codes mixed in.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [3:0] shift);
    logic signed [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return raw >>> shift;
    endcase
  endfunction

  // Present one sample word, with an optional gap first; hold valid high when
  // the next word follows back to back.
  task automatic send_sample(input logic [BAND_W-1:0] b, input logic [SAMPLE_W-1:0] l,
                             input logic [SAMPLE_W-1:0] r, input logic last);
    if (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b;
    in_tdata  <= {r, l};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline drain
  // of samples that produce no word.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write sensitivity, optionally history_length, then one unmapped index
  // that the block must ignore. Valid stays high across the burst.
  task automatic write_regs(input logic [CFG_DATA_W-1:0] sens, input bit touch_len,
                            input logic [CFG_DATA_W-1:0] len_raw);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SENSITIVITY;
    cfg_data  <= sens;
    do @(posedge clk); while (!cfg_ready);
    if (touch_len) begin
      cfg_index <= REG_HISTORY_LENGTH;
      cfg_data  <= len_raw;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_index <= CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_HISTORY_LENGTH + 1));
    cfg_data  <= CFG_DATA_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random bands in any order; each chunk gets its own loudness so that chunk
  // energies spread widely and beats land on both sides of the threshold.
  task automatic random_phase(input int count);
    logic [BAND_W-1:0] b;
    logic              last;
    repeat (count) begin
      b    = BAND_W'($urandom_range(BANDS - 1));
      last = ($urandom_range(6) == 0);
      send_sample(b, pick_sample(amp_shift[b]), pick_sample(amp_shift[b]), last);
      if (last) amp_shift[b] = 4'($urandom_range(15));
    end
  endtask

  initial begin
    foreach (amp_shift[i]) amp_shift[i] = 4'($urandom_range(15));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, empty history.
    // Silent one-sample chunk: zero energy against an empty history, no beat.
    send_sample(3'd0, 16'h0000, 16'h0000, 1'b1);
    // Loudest sample alone: empty history makes it a beat.
    send_sample(3'd1, 16'h8000, 16'h8000, 1'b1);
    // Two-sample chunk across both extremes and the smallest magnitudes.
    send_sample(3'd2, 16'h7FFF, 16'h8000, 1'b0);
    send_sample(3'd2, 16'h0001, 16'hFFFF, 1'b1);
    send_sample(3'd7, 16'hFFFF, 16'h0001, 1'b1);
    // Interleave two open chunks on different bands.
    send_sample(3'd3, 16'h8000, 16'h7FFF, 1'b0);
    send_sample(3'd4, 16'h5555, 16'hAAAA, 1'b0);
    send_sample(3'd3, 16'hAAAA, 16'h5555, 1'b1);
    send_sample(3'd4, 16'h7FFF, 16'h7FFF, 1'b1);
    send_sample(3'd5, 16'h1234, 16'hEDCB, 1'b1);
    send_sample(3'd6, 16'h00FF, 16'hFF00, 1'b1);
    // Band 1 again: same loud chunk beats, a tiny one after it does not.
    send_sample(3'd1, 16'h8000, 16'h8000, 1'b1);
    send_sample(3'd1, 16'h0001, 16'h0000, 1'b1);
    // Leave a partial chunk open across the config write; accumulators survive.
    send_sample(3'd6, 16'h4000, 16'hC000, 1'b0);

    // Zero sensitivity, shortest history: any nonzero chunk beats.
    write_regs(12'd0, 1'b1, 12'd1);
    random_phase(160);
    // Highest sensitivity, deepest history.
    write_regs(12'd4095, 1'b1, 12'd64);
    random_phase(160);
    // Change sensitivity only, history kept; run gap-free on both sides.
    write_regs(12'd256, 1'b0, 12'd0);
    calm <= 1'b1;
    random_phase(160);
    calm <= 1'b0;
    // Length 0 (acts as 1), with junk in the unused data bits.
    write_regs(12'd1, 1'b1, 12'hF80);
    random_phase(140);
    // Length above depth clamps to the depth.
    write_regs(CFG_DATA_W'($urandom), 1'b1, 12'd127);
    random_phase(160);
    write_regs(CFG_DATA_W'($urandom), 1'b1,
               CFG_DATA_W'({$urandom_range(31), 7'($urandom_range(HIST_DEPTH, 1))}));
    random_phase(160);

    // Back to reset values; run one long full-scale chunk on one band.
    write_regs(SENS_RESET, 1'b1, CFG_DATA_W'(LEN_RESET));
    repeat (LONG_RUN) send_sample(3'd5, 16'h8000, 16'h8000, 1'b0);
    send_sample(3'd5, 16'h8000, 16'h8000, 1'b1);
    random_phase(60);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("band_energy_beat_detector_tb: PASS");
    end else begin
      $display("band_energy_beat_detector_tb: FAIL");
    end
    $finish;
  end

endmodule
